@@ rtl/sbga_pkg.sv @@
// ----------------------------------------------------------------------------
// sbga_pkg
// Shared constants and controller/datapath interface types for the sparse
// bitmap group array.
// ----------------------------------------------------------------------------
package sbga_pkg;

	// Geometry of the sparse array
	localparam int GROUP_SLOTS = 32;
	localparam int GROUP_TOTAL = 16;
	localparam int VALUE_BYTES = 8;

	localparam int SLOT_W      = $clog2(GROUP_SLOTS);
	localparam int GROUP_W     = $clog2(GROUP_TOTAL);
	localparam int FILL_W      = SLOT_W + 1;
	localparam int STORE_DEPTH = GROUP_SLOTS * GROUP_TOTAL;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Field widths
	localparam int INDEX_W  = 9;
	localparam int VALUE_W  = 64;
	localparam int LEN_W    = 4;
	localparam int LIMIT_W  = 10;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = LEN_W + VALUE_W;

	// Stream payload widths, padded to whole bytes
	localparam int IN_W  = 80;
	localparam int OUT_W = 72;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

	// Action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_TOO_LONG  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_UNUSED    = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;      // latch the accepted item
		logic rank;         // register packed offset of the position
		logic load_k;       // load shift counter from the group fill
		logic shift_rd;     // read entry k-1, queue its write to k
		logic get_rd;       // read the entry at the packed offset
		logic write_entry;  // write new entry, update bitmap and fill
		logic res_load;     // build the result word
		logic load_out;     // move result into the output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic err_range;
		logic err_long;
		logic is_set;
		logic occupied;
		logic shift_more;
		logic pend_wr;
	} dp_sts_t;

endpackage

@@ rtl/sparse_bitmap_group_array.sv @@
// ----------------------------------------------------------------------------
// sparse_bitmap_group_array
// Sparse array of bitmap-indexed groups with packed value entries; serves
// get and set requests one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream (tuser = action, 0 get / 1 set) and each
//   produces exactly one response transfer on the m_ stream. The user must
//   write index_limit (cfg_wr_en / cfg_wr_data) only while the block is idle.
//   The block does not enforce this. Sequence from acceptance to ready:
//     errors and overwriting sets: rank, decide, done
//     gets: rank, decide, registered store read, done
//     inserting sets: rank, decide, shift, final write, done; the shift
//     moves entries up; the store's single write port moves one entry a cycle.
//   Response appears in the output register at the end of the item; the next
//   request is taken while that response still waits.
//   Reset clears the bitmaps and fill counts at once and sets index_limit to
//   512; no clearing pass is needed since only written entries are read.
//   A stalled receiver holds m_tvalid and m_tdata; the block then finishes
//   the next item and waits with it until the output register frees.
// ----------------------------------------------------------------------------
module sparse_bitmap_group_array
	import sbga_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // index[8:0], write_value[72:9], write_len[76:73]
	input  logic               s_tuser,   // action
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata    // status[1:0], found[2], read_value[66:3],
	                                      // read_len[70:67]
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	sbga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sbga_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.m_tdata     (m_tdata)
	);

`ifndef SYNTHESIS
	// Entry write must never collide with a queued shift write
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry |-> !sts.pend_wr)
		else $error("entry write collides with shift write");

	// No store traffic while waiting for a request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.shift_rd && !cmd.write_entry && !sts.pend_wr)
		else $error("store access while idle");

	// Response status is always a defined code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[STATUS_W-1:0] != STAT_UNUSED)
		else $error("undefined status code");
`endif

endmodule

@@ rtl/sbga_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbga_ctrl
// Sequencer for the sparse bitmap group array: accepts an item, steps the
// datapath through rank and then a store read or shift and write, and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module sbga_ctrl
	import sbga_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANK,
		ST_DECIDE,
		ST_GET_WAIT,
		ST_SHIFT,
		ST_FINAL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Command decode per state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = s_tvalid;
			end
			ST_RANK: begin
				cmd.rank = 1'b1;
			end
			ST_DECIDE: begin
				if (sts.err_range || !sts.is_set) begin
					// range errors finish here; a get issues its read
					cmd.get_rd   = !sts.err_range;
					cmd.res_load = sts.err_range;
				end else if (sts.err_long) begin
					cmd.res_load = 1'b1;
				end else if (sts.occupied) begin
					cmd.write_entry = 1'b1;
					cmd.res_load    = 1'b1;
				end else begin
					cmd.load_k = 1'b1;
				end
			end
			ST_GET_WAIT: begin
				cmd.res_load = 1'b1;
			end
			ST_SHIFT: begin
				cmd.shift_rd = sts.shift_more;
			end
			ST_FINAL: begin
				cmd.write_entry = 1'b1;
				cmd.res_load    = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_RANK;
				end
				ST_RANK: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (sts.err_range)
						state_q <= ST_DONE;
					else if (!sts.is_set)
						state_q <= ST_GET_WAIT;
					else if (sts.err_long || sts.occupied)
						state_q <= ST_DONE;
					else
						state_q <= ST_SHIFT;
				end
				ST_GET_WAIT: begin
					state_q <= ST_DONE;
				end
				ST_SHIFT: begin
					// last queued write retires in the cycle that exits
					if (!sts.shift_more)
						state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/sbga_datapath.sv @@
// ----------------------------------------------------------------------------
// sbga_datapath
// Item registers, per-group bitmaps and fill counts, the packed entry store,
// rank logic, shift pointer, result staging and the output register.
// ----------------------------------------------------------------------------
module sbga_datapath
	import sbga_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               s_tuser,
	input  logic [IN_W-1:0]    s_tdata,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output logic [OUT_W-1:0]   m_tdata
);

	// Bytes below len are kept
	function automatic logic [VALUE_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [VALUE_W-1:0] m;
		m = '0;
		for (int b = 0; b < VALUE_BYTES; b++)
			m[8*b +: 8] = (LEN_W'(b) < len) ? 8'hff : 8'h00;
		return m;
	endfunction

	// Ones count over one group bitmap, folded in pairs, nibbles, bytes, halves and words
	function automatic logic [FILL_W-1:0] count_ones(input logic [GROUP_SLOTS-1:0] x);
		logic [31:0] v;
		v = x - ((x >> 1) & 32'h5555_5555);
		v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
		v = (v + (v >> 4)) & 32'h0f0f_0f0f;
		v = v + (v >> 8);
		v = v + (v >> 16);
		return v[FILL_W-1:0];
	endfunction

	logic [LIMIT_W-1:0]     limit_q;
	logic                   action_q;
	logic [INDEX_W-1:0]     idx_q;
	logic [VALUE_W-1:0]     wval_q;
	logic [LEN_W-1:0]       wlen_q;
	logic [GROUP_SLOTS-1:0] occ_q  [GROUP_TOTAL];
	logic [FILL_W-1:0]      fill_q [GROUP_TOTAL];
	logic [ENTRY_W-1:0]     store_q [STORE_DEPTH];
	logic [ENTRY_W-1:0]     rdata_q;
	logic [SLOT_W-1:0]      off_q;
	logic [SLOT_W-1:0]      k_q;
	logic                   pend_q;
	logic [ADDR_W-1:0]      pend_addr_q;
	logic [OUT_W-1:0]       res_q;
	logic [OUT_W-1:0]       out_q;

	logic [GROUP_W-1:0]     grp;
	logic [SLOT_W-1:0]      pos;
	logic [GROUP_SLOTS-1:0] cur_bits;
	logic [GROUP_SLOTS-1:0] below_mask;
	logic [FILL_W-1:0]      cur_fill;
	logic [FILL_W-1:0]      rank_cnt;
	logic                   occupied;
	logic                   err_range;
	logic                   err_long;
	logic [ADDR_W-1:0]      entry_addr;
	logic [ADDR_W-1:0]      rd_addr;
	logic [VALUE_W-1:0]     rd_val;
	logic [LEN_W-1:0]       rd_len;
	logic                   found;
	logic [OUT_W-1:0]       res_next;

	// Position decode
	assign grp        = idx_q[SLOT_W +: GROUP_W];
	assign pos        = idx_q[SLOT_W-1:0];
	assign cur_bits   = occ_q[grp];
	assign cur_fill   = fill_q[grp];
	assign occupied   = cur_bits[pos];
	assign below_mask = (GROUP_SLOTS'(1) << pos) - GROUP_SLOTS'(1);
	assign rank_cnt   = count_ones(cur_bits & below_mask);
	assign err_range  = ({1'b0, idx_q} >= limit_q)
		|| (LIMIT_W'(idx_q >> SLOT_W) >= LIMIT_W'(GROUP_TOTAL));
	assign err_long   = (wlen_q > LEN_W'(VALUE_BYTES));
	assign entry_addr = {grp, off_q};
	assign rd_addr    = cmd.shift_rd ? {grp, SLOT_W'(k_q - 1'b1)} : entry_addr;
	assign rd_len     = rdata_q[ENTRY_W-1 -: LEN_W];
	assign rd_val     = rdata_q[VALUE_W-1:0];
	assign found      = occupied && (rd_len != '0);

	always_comb begin
		sts            = '0;
		sts.err_range  = err_range;
		sts.err_long   = err_long;
		sts.is_set     = (action_q == ACT_SET);
		sts.occupied   = occupied;
		sts.shift_more = (k_q > off_q);
		sts.pend_wr    = pend_q;
	end

	assign m_tdata = out_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= s_tuser;
			idx_q    <= s_tdata[INDEX_W-1:0];
			wval_q   <= s_tdata[INDEX_W +: VALUE_W];
			wlen_q   <= s_tdata[INDEX_W+VALUE_W +: LEN_W];
		end
	end

	// Bitmaps and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUP_TOTAL; g++) begin
				occ_q[g]  <= '0;
				fill_q[g] <= '0;
			end
		end else if (cmd.write_entry && !occupied) begin
			occ_q[grp][pos] <= 1'b1;
			if (cur_fill < FILL_W'(GROUP_SLOTS))
				fill_q[grp] <= cur_fill + 1'b1;
		end
	end

	// Rank and shift pointer
	always_ff @(posedge clk) begin
		if (cmd.rank)
			off_q <= rank_cnt[SLOT_W-1:0];
		if (cmd.load_k)
			k_q <= (cur_fill > FILL_W'(GROUP_SLOTS - 1)) ? SLOT_W'(GROUP_SLOTS - 1)
				: cur_fill[SLOT_W-1:0];
		else if (cmd.shift_rd)
			k_q <= SLOT_W'(k_q - 1'b1);
	end

	// Queued shift write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= cmd.shift_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_rd)
			pend_addr_q <= {grp, k_q};
	end

	// Packed entry store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.write_entry)
			store_q[entry_addr] <= {wlen_q, wval_q & byte_mask(wlen_q)};
		else if (pend_q)
			store_q[pend_addr_q] <= rdata_q;
		if (cmd.shift_rd || cmd.get_rd)
			rdata_q <= store_q[rd_addr];
	end

	// Result word for the current item
	always_comb begin
		res_next = '0;
		if (err_range)
			res_next[STATUS_W-1:0] = STAT_RANGE;
		else if (action_q == ACT_SET && err_long)
			res_next[STATUS_W-1:0] = STAT_TOO_LONG;
		else if (action_q == ACT_GET && found) begin
			res_next[STATUS_W-1:0]               = STAT_OK;
			res_next[STATUS_W]                   = 1'b1;
			res_next[STATUS_W+1 +: VALUE_W]       = rd_val & byte_mask(rd_len);
			res_next[STATUS_W+1+VALUE_W +: LEN_W] = rd_len;
		end
	end

	// Result staging and output register
	always_ff @(posedge clk) begin
		if (cmd.res_load)
			res_q <= res_next;
		if (cmd.load_out)
			out_q <= res_q;
	end

endmodule
